/* design/apss_pkg.sv */
`timescale 1ns / 1ps

package apss_pkg;

   // Power state codes as they appear on the result stream.
   typedef enum logic [3:0] {
      ST_G3   = 4'd0,
      ST_S5   = 4'd1,
      ST_S3   = 4'd2,
      ST_S0   = 4'd3,
      ST_G3S5 = 4'd4,
      ST_S5S3 = 4'd5,
      ST_S3S0 = 4'd6,
      ST_S0S3 = 4'd7,
      ST_S3S5 = 4'd8,
      ST_S5G3 = 4'd9
   } pstate_type;

   // Sub-steps inside a transition state.
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   // Bit positions in the output level vector.
   localparam int L_SUSVR  = 0;
   localparam int L_MEM    = 1;
   localparam int L_RUN    = 2;
   localparam int L_CORE   = 3;
   localparam int L_RSM    = 4;
   localparam int L_SYSOK  = 5;
   localparam int L_COREOK = 6;
   localparam int L_THR    = 7;
   localparam int L_TPAD   = 8;
   localparam int L_TSCR   = 9;
   localparam int L_RADIO  = 10;
   localparam int NUM_LEVELS = 11;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_STOP_IN_S5      = 2'd0;
   localparam logic [1:0] REG_RAIL_WAIT_LIMIT = 2'd1;
   localparam logic [1:0] REG_SUSPEND_SETTLE  = 2'd2;
   localparam logic [1:0] REG_RUN_SETTLE      = 2'd3;

   localparam logic        RST_STOP_IN_S5      = 1'b1;
   localparam logic [15:0] RST_RAIL_WAIT_LIMIT = 16'd100;
   localparam logic [9:0]  RST_SUSPEND_SETTLE  = 10'd10;
   localparam logic [9:0]  RST_RUN_SETTLE      = 10'd100;

   // One input transaction; the last member sits in bit 0.
   typedef struct packed {
      logic force_off;
      logic throttle_request;
      logic power_on_request;
      logic lid_open;
      logic sleep_s4_n;
      logic sleep_s3_n;
      logic pgood_main5v;
      logic pgood_suspend;
   } req_type;

   typedef struct packed {
      logic        stop_in_s5;
      logic [15:0] rail_wait_limit;
      logic [9:0]  suspend_settle_ticks;
      logic [9:0]  run_settle_ticks;
   } cfg_type;

   typedef struct packed {
      pstate_type              pwr_state;
      logic [1:0]              phase;
      logic [15:0]             wait_count;
      logic [NUM_LEVELS-1:0]   levels;
   } seq_type;

endpackage

/* design/apss_step.sv */
`timescale 1ns / 1ps

// Next-state logic of the sequencer: one tick applied to the current state.
module apss_step
   import apss_pkg::*;
(
   input  seq_type cur,
   input  req_type req,
   input  cfg_type cfg,
   output seq_type nxt
);

   logic [15:0] wc_inc;
   logic        rail_timeout;
   logic        sus_settled;
   logic        run_settled;
   logic        pg_both;

   assign wc_inc       = cur.wait_count + 16'd1;
   assign rail_timeout = ({1'b0, cur.wait_count} + 17'd1) >= {1'b0, cfg.rail_wait_limit};
   assign sus_settled  = cur.wait_count >= {6'd0, cfg.suspend_settle_ticks};
   assign run_settled  = cur.wait_count >= {6'd0, cfg.run_settle_ticks};
   assign pg_both      = req.pgood_suspend & req.pgood_main5v;

   always_comb begin
      nxt = cur;
      case (cur.pwr_state)
         ST_G3: begin
            if (req.power_on_request) begin
               nxt.pwr_state  = ST_G3S5;
               nxt.phase      = PH_FIRST;
               nxt.wait_count = '0;
            end
         end
         ST_S5: begin
            if (req.sleep_s4_n) begin
               nxt.pwr_state  = ST_S5S3;
               nxt.phase      = PH_FIRST;
               nxt.wait_count = '0;
            end
         end
         ST_S3: begin
            nxt.levels[L_TSCR] = req.lid_open;
            if (!req.pgood_suspend) begin
               nxt.levels[L_SYSOK] = 1'b0;
               nxt.levels[L_RSM]   = 1'b0;
               nxt.pwr_state       = ST_S3S5;
               nxt.phase           = PH_FIRST;
               nxt.wait_count      = '0;
            end else if (req.sleep_s3_n) begin
               nxt.pwr_state  = ST_S3S0;
               nxt.phase      = PH_FIRST;
               nxt.wait_count = '0;
            end else if (!req.sleep_s4_n) begin
               nxt.pwr_state  = ST_S3S5;
               nxt.phase      = PH_FIRST;
               nxt.wait_count = '0;
            end
         end
         ST_S0: begin
            nxt.levels[L_THR] = req.throttle_request;
            if (!pg_both) begin
               nxt.levels[L_SYSOK] = 1'b0;
               nxt.levels[L_RSM]   = 1'b0;
               nxt.pwr_state       = ST_S0S3;
               nxt.phase           = PH_FIRST;
               nxt.wait_count      = '0;
            end else if (!req.sleep_s3_n) begin
               nxt.pwr_state  = ST_S0S3;
               nxt.phase      = PH_FIRST;
               nxt.wait_count = '0;
            end
         end
         ST_G3S5: begin
            if (cur.phase == PH_SECOND) begin
               if (req.pgood_suspend) begin
                  nxt.levels[L_RSM] = 1'b1;
                  nxt.phase         = PH_THIRD;
                  nxt.wait_count    = '0;
               end else if (rail_timeout) begin
                  nxt.levels[L_SYSOK] = 1'b0;
                  nxt.levels[L_RSM]   = 1'b0;
                  nxt.pwr_state       = ST_G3;
                  nxt.phase           = PH_FIRST;
                  nxt.wait_count      = '0;
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end else if (cur.phase == PH_THIRD) begin
               if (sus_settled) begin
                  nxt.pwr_state  = ST_S5;
                  nxt.phase      = PH_FIRST;
                  nxt.wait_count = '0;
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end else begin
               if (sus_settled) begin
                  nxt.levels[L_SUSVR] = 1'b1;
                  nxt.phase           = PH_SECOND;
                  nxt.wait_count      = '0;
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end
         end
         ST_S5S3: begin
            if (req.pgood_suspend) begin
               if (cur.phase == PH_SECOND) begin
                  nxt.levels[L_TPAD] = 1'b1;
                  nxt.pwr_state      = ST_S3;
                  nxt.phase          = PH_FIRST;
                  nxt.wait_count     = '0;
               end else begin
                  nxt.levels[L_MEM] = 1'b1;
                  nxt.phase         = PH_SECOND;
                  nxt.wait_count    = '0;
               end
            end else if (rail_timeout) begin
               nxt.levels[L_SYSOK] = 1'b0;
               nxt.levels[L_RSM]   = 1'b0;
               nxt.pwr_state       = ST_S5G3;
               nxt.phase           = PH_FIRST;
               nxt.wait_count      = '0;
            end else begin
               nxt.wait_count = wc_inc;
            end
         end
         ST_S3S0: begin
            if (cur.phase == PH_SECOND) begin
               if (pg_both) begin
                  nxt.levels[L_CORE] = 1'b1;
                  nxt.phase          = PH_THIRD;
                  nxt.wait_count     = '0;
               end else if (rail_timeout) begin
                  nxt.levels[L_SYSOK] = 1'b0;
                  nxt.levels[L_RSM]   = 1'b0;
                  nxt.levels[L_RADIO] = 1'b0;
                  nxt.levels[L_RUN]   = 1'b0;
                  nxt.levels[L_TSCR]  = 1'b0;
                  nxt.pwr_state       = ST_S3;
                  nxt.phase           = PH_FIRST;
                  nxt.wait_count      = '0;
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end else if (cur.phase == PH_THIRD) begin
               if (run_settled) begin
                  nxt.levels[L_THR]    = req.throttle_request;
                  nxt.levels[L_SYSOK]  = 1'b1;
                  nxt.levels[L_COREOK] = 1'b1;
                  nxt.pwr_state        = ST_S0;
                  nxt.phase            = PH_FIRST;
                  nxt.wait_count       = '0;
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end else begin
               nxt.levels[L_RUN]   = 1'b1;
               nxt.levels[L_RADIO] = 1'b1;
               nxt.levels[L_TSCR]  = 1'b1;
               nxt.phase           = PH_SECOND;
               nxt.wait_count      = '0;
            end
         end
         ST_S0S3: begin
            nxt.levels[L_SYSOK]  = 1'b0;
            nxt.levels[L_COREOK] = 1'b0;
            nxt.levels[L_CORE]   = 1'b0;
            nxt.levels[L_RADIO]  = 1'b0;
            nxt.levels[L_THR]    = 1'b0;
            nxt.levels[L_RUN]    = 1'b0;
            nxt.pwr_state        = ST_S3;
            nxt.phase            = PH_FIRST;
            nxt.wait_count       = '0;
         end
         ST_S3S5: begin
            nxt.levels[L_RADIO] = 1'b0;
            nxt.levels[L_TPAD]  = 1'b0;
            nxt.levels[L_MEM]   = 1'b0;
            nxt.pwr_state       = cfg.stop_in_s5 ? ST_S5 : ST_S5G3;
            nxt.phase           = PH_FIRST;
            nxt.wait_count      = '0;
         end
         ST_S5G3: begin
            nxt.levels[L_RSM]   = 1'b0;
            nxt.levels[L_SUSVR] = 1'b0;
            nxt.pwr_state       = ST_G3;
            nxt.phase           = PH_FIRST;
            nxt.wait_count      = '0;
         end
         default: begin
            nxt.pwr_state  = ST_G3;
            nxt.phase      = PH_FIRST;
            nxt.wait_count = '0;
         end
      endcase

      // Forced shutdown applies after the state's own actions.
      if (req.force_off) begin
         nxt.levels[L_SYSOK] = 1'b0;
         nxt.levels[L_RSM]   = 1'b0;
      end
   end

endmodule

/* design/acpi_power_state_sequencer.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake              | Contents
// req_     | in  | tvalid/tready          | one tick: sampled power-good, sleep and request lines
// rsp_     | out | tvalid/tready          | power state and all output levels after the tick
// csr_     | in  | psel/penable/pready    | four configuration registers, 32-bit data
//
// Every tick transaction yields exactly one result transaction. A tick is first held in the
// input register, and the sequencer state is updated as it moves into the result register.
// A new tick is accepted every cycle while the result side does not stall; a stalled
// result holds the result register and the input register fills behind it before
// req_tready drops.
// Reset is synchronous and active high: state G3, all levels low, registers at defaults.

module acpi_power_state_sequencer
   import apss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] pgood_suspend, [1] pgood_main5v, [2] sleep_s3_n, [3] sleep_s4_n,
   // [4] lid_open, [5] power_on_request, [6] throttle_request, [7] force_off
   input  logic [7:0]  req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] pwr_state, [4] suspend_vr_en, [5] memory_rail_en, [6] run_rails_en,
   // [7] core_rail_en, [8] resume_reset_n, [9] system_pwrok, [10] core_pwrok,
   // [11] cpu_throttle, [12] touchpad_en, [13] touchscreen_reset_n, [14] radio_en,
   // [15] zero
   output logic [15:0] rsp_tdata,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   cfg_type    cfg_ff;
   logic [1:0] csr_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_in_s5           <= RST_STOP_IN_S5;
         cfg_ff.rail_wait_limit      <= RST_RAIL_WAIT_LIMIT;
         cfg_ff.suspend_settle_ticks <= RST_SUSPEND_SETTLE;
         cfg_ff.run_settle_ticks     <= RST_RUN_SETTLE;
      end else if (csr_write) begin
         case (csr_index)
            REG_STOP_IN_S5:      cfg_ff.stop_in_s5           <= csr_pwdata[0];
            REG_RAIL_WAIT_LIMIT: cfg_ff.rail_wait_limit      <= csr_pwdata[15:0];
            REG_SUSPEND_SETTLE:  cfg_ff.suspend_settle_ticks <= csr_pwdata[9:0];
            REG_RUN_SETTLE:      cfg_ff.run_settle_ticks     <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STOP_IN_S5:      csr_prdata = {31'd0, cfg_ff.stop_in_s5};
         REG_RAIL_WAIT_LIMIT: csr_prdata = {16'd0, cfg_ff.rail_wait_limit};
         REG_SUSPEND_SETTLE:  csr_prdata = {22'd0, cfg_ff.suspend_settle_ticks};
         REG_RUN_SETTLE:      csr_prdata = {22'd0, cfg_ff.run_settle_ticks};
         default:             csr_prdata = '0;
      endcase
   end

   // Input register. It advances whenever the result register is free or being
   // drained this cycle, so back-to-back ticks flow without a bubble.
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    advance;

   assign advance    = in_valid_ff & (~rsp_tvalid | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_type'(req_tdata);
      end
   end

   // Sequencer state, updated once per tick as it passes into the result register.
   seq_type seq_ff;
   seq_type seq_in;

   apss_step u_step (
      .cur (seq_ff),
      .req (in_data_ff),
      .cfg (cfg_ff),
      .nxt (seq_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.pwr_state  <= ST_G3;
         seq_ff.phase      <= PH_FIRST;
         seq_ff.wait_count <= '0;
         seq_ff.levels     <= '0;
      end else if (advance) begin
         seq_ff <= seq_in;
      end
   end

   // Result register. The levels in seq_ff are the result of the last tick, so the
   // payload is taken straight from the state and only the valid flag is kept here.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, seq_ff.levels, seq_ff.pwr_state};

endmodule

/* dv/tb_acpi_power_state_sequencer.sv */
`timescale 1ns / 1ps

module tb_acpi_power_state_sequencer
   import apss_pkg::*;
;

   // The run is cut off here if the block stops moving. The slowest correct run, with one
   // long hold-off and the register accesses, stays well under this limit.
   localparam int CYCLE_LIMIT  = 300000;
   // Length of the long receiver hold-off in the back-pressure phase.
   localparam int HOLD_CYCLES  = 120;
   // Cycles allowed after the last result of a phase.
   localparam int SETTLE_DELAY = 6;
   localparam int NUM_PHASES   = 7;

   // Verdict of one tick spent waiting on a power-good input.
   typedef enum {RAIL_PENDING, RAIL_GOOD, RAIL_TIMED_OUT} rail_verdict_type;

   // What the sequencer shows after one tick: its state and all eleven levels.
   typedef struct packed {
      pstate_type             state;
      logic [NUM_LEVELS-1:0]  levels;
   } sequencer_out_type;

   // One row of the directed walk. Rows with typed set carry a hand-written result,
   // the others are checked against the sequencer model below.
   typedef struct {
      req_type                tick;
      bit                     typed;
      pstate_type             state;
      logic [NUM_LEVELS-1:0]  levels;
   } walk_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [0] pgood_suspend, [1] pgood_main5v, [2] sleep_s3_n, [3] sleep_s4_n,
   // [4] lid_open, [5] power_on_request, [6] throttle_request, [7] force_off
   logic [7:0]  req_tdata = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   // [3:0] pwr_state, [4] suspend_vr_en, [5] memory_rail_en, [6] run_rails_en,
   // [7] core_rail_en, [8] resume_reset_n, [9] system_pwrok, [10] core_pwrok,
   // [11] cpu_throttle, [12] touchpad_en, [13] touchscreen_reset_n, [14] radio_en,
   // [15] zero
   logic [15:0] rsp_tdata;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Our own copy of the sequencer: registers, state, sub-step, tick counter, levels.
   cfg_type               sequencer_cfg;
   pstate_type            seq_state;
   logic [1:0]            seq_phase;
   logic [15:0]           seq_count;
   logic [NUM_LEVELS-1:0] seq_levels;

   // Results the block still owes, oldest first.
   sequencer_out_type due_outputs [$];

   // Slowly moving board lines used to build plausible random ticks.
   bit line_pgood_sus  = 1'b1;
   bit line_pgood_5v   = 1'b1;
   bit line_s3_n       = 1'b0;
   bit line_s4_n       = 1'b1;
   bit line_lid        = 1'b1;

   // Idle behavior of both sides, set per phase by the main sequence.
   bit tx_idle   = 1'b1;
   bit rx_idle   = 1'b1;
   bit hold_long = 1'b0;

   int          mismatches     = 0;
   int          results_checked = 0;
   int          ticks_sent     = 0;
   int          input_stalls   = 0;
   int          cycle_count    = 0;
   logic [15:0] states_seen    = '0;

   string level_name [NUM_LEVELS] = '{
      "suspend_vr_en", "memory_rail_en", "run_rails_en", "core_rail_en",
      "resume_reset_n", "system_pwrok", "core_pwrok", "cpu_throttle",
      "touchpad_en", "touchscreen_reset_n", "radio_en"};

   // Directed walk, run with settle times of zero and a rail wait limit of two.
   // Tick bits from the top: force_off, throttle, power_on, lid, s4_n, s3_n, 5V, suspend.
   walk_row_type walk_rows [25] = '{
      // Right after reset nothing moves without a power-on request.
      '{8'h00, 1'b1, ST_G3,   11'd0},
      // A forced shutdown in G3 has nothing left to drop.
      '{8'h80, 1'b1, ST_G3,   11'd0},
      // Power-on request leaves G3; nothing is enabled yet.
      '{8'h20, 1'b1, ST_G3S5, 11'd0},
      // Zero settle: the suspend regulator comes on at once, then one tick without
      // suspend power-good, then it arrives and the resume reset is released.
      '{8'h00, 1'b0, ST_G3,   11'd0},
      '{8'h00, 1'b0, ST_G3,   11'd0},
      '{8'h01, 1'b0, ST_G3,   11'd0},
      '{8'h01, 1'b0, ST_G3,   11'd0},
      // S5 to S3: memory rail, then touchpad.
      '{8'h09, 1'b0, ST_G3,   11'd0},
      '{8'h01, 1'b0, ST_G3,   11'd0},
      '{8'h01, 1'b0, ST_G3,   11'd0},
      // S3 with the lid open and an S3 wake, then the run rails and power-ok.
      '{8'h1D, 1'b0, ST_G3,   11'd0},
      '{8'h0D, 1'b0, ST_G3,   11'd0},
      '{8'h0F, 1'b0, ST_G3,   11'd0},
      '{8'h4F, 1'b0, ST_G3,   11'd0},
      // In S0 the throttle follows its request; then a forced shutdown.
      '{8'h0F, 1'b0, ST_G3,   11'd0},
      '{8'hCF, 1'b0, ST_G3,   11'd0},
      // Suspend power-good lost in S0, then back down to S3.
      '{8'h0E, 1'b0, ST_G3,   11'd0},
      '{8'h00, 1'b0, ST_G3,   11'd0},
      // Wake again, but the run rails never come good and the wait times out.
      '{8'h0D, 1'b0, ST_G3,   11'd0},
      '{8'h0D, 1'b0, ST_G3,   11'd0},
      '{8'h0C, 1'b0, ST_G3,   11'd0},
      '{8'h0C, 1'b0, ST_G3,   11'd0},
      // Both sleep lines low in S3 shut down; with the stop bit set it stays in S5.
      '{8'h01, 1'b0, ST_G3,   11'd0},
      '{8'h7F, 1'b0, ST_G3,   11'd0},
      '{8'h00, 1'b0, ST_G3,   11'd0}};

   acpi_power_state_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Sequencer model
   // ---------------------------------------------------------------------------

   function automatic void enter_state(input pstate_type s);
      seq_state = s;
      seq_phase = PH_FIRST;
      seq_count = '0;
   endfunction

   // A forced shutdown drops system power-ok and puts the resume well in reset.
   function automatic void force_shutdown();
      seq_levels[L_SYSOK] = 1'b0;
      seq_levels[L_RSM]   = 1'b0;
   endfunction

   // True once the settle time has run out; otherwise one more tick is counted.
   function automatic bit settle_done(input logic [9:0] ticks);
      if (seq_count >= ticks) begin
         return 1'b1;
      end
      seq_count++;
      return 1'b0;
   endfunction

   // A limit of zero gives up on the first tick, just as a limit of one does.
   function automatic rail_verdict_type check_rail(input bit good);
      if (good) begin
         return RAIL_GOOD;
      end
      if (int'(seq_count) + 1 >= int'(sequencer_cfg.rail_wait_limit)) begin
         return RAIL_TIMED_OUT;
      end
      seq_count++;
      return RAIL_PENDING;
   endfunction

   // Moves the model on by one tick and returns what the block must show after it.
   function automatic sequencer_out_type advance_sequencer(input req_type t);
      rail_verdict_type  verdict;
      sequencer_out_type r;
      case (seq_state)
         ST_G3: begin
            if (t.power_on_request) enter_state(ST_G3S5);
         end
         ST_S5: begin
            if (t.sleep_s4_n) enter_state(ST_S5S3);
         end
         ST_S3: begin
            seq_levels[L_TSCR] = t.lid_open;
            if (!t.pgood_suspend) begin
               force_shutdown();
               enter_state(ST_S3S5);
            end else if (t.sleep_s3_n) begin
               enter_state(ST_S3S0);
            end else if (!t.sleep_s4_n) begin
               enter_state(ST_S3S5);
            end
         end
         ST_S0: begin
            seq_levels[L_THR] = t.throttle_request;
            if (!(t.pgood_suspend && t.pgood_main5v)) begin
               force_shutdown();
               enter_state(ST_S0S3);
            end else if (!t.sleep_s3_n) begin
               enter_state(ST_S0S3);
            end
         end
         ST_G3S5: begin
            if (seq_phase == PH_SECOND) begin
               verdict = check_rail(t.pgood_suspend);
               if (verdict == RAIL_GOOD) begin
                  seq_levels[L_RSM] = 1'b1;
                  seq_phase = PH_THIRD;
                  seq_count = '0;
               end else if (verdict == RAIL_TIMED_OUT) begin
                  force_shutdown();
                  enter_state(ST_G3);
               end
            end else if (seq_phase == PH_THIRD) begin
               if (settle_done(sequencer_cfg.suspend_settle_ticks)) enter_state(ST_S5);
            end else if (settle_done(sequencer_cfg.suspend_settle_ticks)) begin
               // An unused sub-step code lands here too and starts over.
               seq_levels[L_SUSVR] = 1'b1;
               seq_phase = PH_SECOND;
               seq_count = '0;
            end
         end
         ST_S5S3: begin
            verdict = check_rail(t.pgood_suspend);
            if (verdict == RAIL_TIMED_OUT) begin
               force_shutdown();
               enter_state(ST_S5G3);
            end else if (verdict == RAIL_GOOD) begin
               if (seq_phase == PH_SECOND) begin
                  seq_levels[L_TPAD] = 1'b1;
                  enter_state(ST_S3);
               end else begin
                  seq_levels[L_MEM] = 1'b1;
                  seq_phase = PH_SECOND;
                  seq_count = '0;
               end
            end
         end
         ST_S3S0: begin
            if (seq_phase == PH_SECOND) begin
               verdict = check_rail(t.pgood_suspend && t.pgood_main5v);
               if (verdict == RAIL_GOOD) begin
                  seq_levels[L_CORE] = 1'b1;
                  seq_phase = PH_THIRD;
                  seq_count = '0;
               end else if (verdict == RAIL_TIMED_OUT) begin
                  force_shutdown();
                  seq_levels[L_RADIO] = 1'b0;
                  seq_levels[L_RUN]   = 1'b0;
                  seq_levels[L_TSCR]  = 1'b0;
                  enter_state(ST_S3);
               end
            end else if (seq_phase == PH_THIRD) begin
               if (settle_done(sequencer_cfg.run_settle_ticks)) begin
                  seq_levels[L_THR]    = t.throttle_request;
                  seq_levels[L_SYSOK]  = 1'b1;
                  seq_levels[L_COREOK] = 1'b1;
                  enter_state(ST_S0);
               end
            end else begin
               seq_levels[L_RUN]   = 1'b1;
               seq_levels[L_RADIO] = 1'b1;
               seq_levels[L_TSCR]  = 1'b1;
               seq_phase = PH_SECOND;
               seq_count = '0;
            end
         end
         ST_S0S3: begin
            seq_levels[L_SYSOK]  = 1'b0;
            seq_levels[L_COREOK] = 1'b0;
            seq_levels[L_CORE]   = 1'b0;
            seq_levels[L_RADIO]  = 1'b0;
            seq_levels[L_THR]    = 1'b0;
            seq_levels[L_RUN]    = 1'b0;
            enter_state(ST_S3);
         end
         ST_S3S5: begin
            seq_levels[L_RADIO] = 1'b0;
            seq_levels[L_TPAD]  = 1'b0;
            seq_levels[L_MEM]   = 1'b0;
            enter_state(sequencer_cfg.stop_in_s5 ? ST_S5 : ST_S5G3);
         end
         ST_S5G3: begin
            seq_levels[L_RSM]   = 1'b0;
            seq_levels[L_SUSVR] = 1'b0;
            enter_state(ST_G3);
         end
         default: begin
            enter_state(ST_G3);
         end
      endcase
      // The force-off line acts at the end of the tick, whatever the state did.
      if (t.force_off) force_shutdown();
      r.state  = seq_state;
      r.levels = seq_levels;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] register_value(input logic [1:0] index);
      case (index)
         REG_STOP_IN_S5:      return {31'd0, sequencer_cfg.stop_in_s5};
         REG_RAIL_WAIT_LIMIT: return {16'd0, sequencer_cfg.rail_wait_limit};
         REG_SUSPEND_SETTLE:  return {22'd0, sequencer_cfg.suspend_settle_ticks};
         default:             return {22'd0, sequencer_cfg.run_settle_ticks};
      endcase
   endfunction

   // One optional write followed by a read that must return the stored value.
   // Upper data bits beyond a register's width are dropped by the block.
   // The bus goes idle at the end, so back-to-back calls never
   // drive the select twice at the same edge.
   task automatic csr_access(input logic [1:0] index, input bit do_write,
                             input logic [31:0] value);
      logic [31:0] readback;
      if (do_write) begin
         csr_psel    <= 1'b1;
         csr_pwrite  <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr   <= {index, 2'b00};
         csr_pwdata  <= value;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (index)
            REG_STOP_IN_S5:      sequencer_cfg.stop_in_s5 = value[0];
            REG_RAIL_WAIT_LIMIT: sequencer_cfg.rail_wait_limit = value[15:0];
            REG_SUSPEND_SETTLE:  sequencer_cfg.suspend_settle_ticks = value[9:0];
            default:             sequencer_cfg.run_settle_ticks = value[9:0];
         endcase
      end
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (readback !== register_value(index)) begin
         $error("register %0d expected %0h actual %0h", index, register_value(index),
                readback);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tick stimulus
   // ---------------------------------------------------------------------------

   // Most ticks look like a real board: rails that stay good for a while and drop
   // out briefly, sleep lines that change now and then. One in ten is pure noise.
   function automatic req_type next_random_tick();
      req_type    t;
      logic [7:0] noise;
      if ($urandom_range(0, 9) == 0) begin
         noise = 8'($urandom_range(0, 255));
         t = noise;
         return t;
      end
      if (line_pgood_sus) line_pgood_sus = ($urandom_range(0, 23) != 0);
      else line_pgood_sus = ($urandom_range(0, 3) == 0);
      if (line_pgood_5v) line_pgood_5v = ($urandom_range(0, 23) != 0);
      else line_pgood_5v = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) line_s3_n = !line_s3_n;
      if ($urandom_range(0, 5) == 0) line_s4_n = !line_s4_n;
      if ($urandom_range(0, 3) == 0) line_lid = !line_lid;
      t.pgood_suspend    = line_pgood_sus;
      t.pgood_main5v     = line_pgood_5v;
      t.sleep_s3_n       = line_s3_n;
      t.sleep_s4_n       = line_s4_n;
      t.lid_open         = line_lid;
      t.power_on_request = ($urandom_range(0, 2) == 0);
      t.throttle_request = 1'($urandom_range(0, 1));
      t.force_off        = ($urandom_range(0, 49) == 0);
      return t;
   endfunction

   // Offers count tick transactions, either the directed walk or random ticks,
   // and records the expected result of each one at the edge where it is taken.
   task automatic drive_ticks(input int count, input bit walk);
      int                i;
      int                gap;
      req_type           tick;
      sequencer_out_type predicted;
      for (i = 0; i < count; i++) begin
         tick = walk ? walk_rows[i].tick : next_random_tick();
         gap  = tx_idle ? $urandom_range(0, 17) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= tick;
         do @(posedge clock); while (!req_tready);
         predicted = advance_sequencer(tick);
         if (walk && walk_rows[i].typed) begin
            due_outputs.push_back({walk_rows[i].state, walk_rows[i].levels});
         end else begin
            due_outputs.push_back(predicted);
         end
         ticks_sent++;
      end
      req_tvalid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stalls drawn per transaction, plus one long hold-off on request
   // so that the block's two registers fill and req_tready drops.
   // ---------------------------------------------------------------------------

   initial begin
      int stall;
      forever begin
         if (hold_long) begin
            stall = HOLD_CYCLES;
            hold_long = 1'b0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 17) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Every result transaction is compared field by field with the oldest one owed.
   always @(posedge clock) begin : rsp_monitor
      sequencer_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         states_seen[rsp_tdata[3:0]] = 1'b1;
         if (due_outputs.size() == 0) begin
            $error("result transaction with no tick outstanding, pwr_state %0d",
                   rsp_tdata[3:0]);
            mismatches++;
         end else begin
            want = due_outputs.pop_front();
            if (rsp_tdata[3:0] !== want.state) begin
               $error("pwr_state expected %0d actual %0d", want.state, rsp_tdata[3:0]);
               mismatches++;
            end
            for (int b = 0; b < NUM_LEVELS; b++) begin
               if (rsp_tdata[4 + b] !== want.levels[b]) begin
                  $error("%s expected %0b actual %0b", level_name[b], want.levels[b],
                         rsp_tdata[4 + b]);
                  mismatches++;
               end
            end
            if (rsp_tdata[15] !== 1'b0) begin
               $error("padding bit expected 0 actual %0b", rsp_tdata[15]);
               mismatches++;
            end
         end
      end
   end

   // Watchdog, and a count of cycles in which the block refused a tick.
   always @(posedge clock) begin
      cycle_count++;
      if (req_tvalid && !req_tready) input_stalls++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("acpi_power_state_sequencer test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence: reset, default check, then one phase per register setting.
   // ---------------------------------------------------------------------------

   initial begin
      int          p;
      int          n_ticks;
      cfg_type     plan;
      logic [31:0] junk;

      sequencer_cfg = {RST_STOP_IN_S5, RST_RAIL_WAIT_LIMIT, RST_SUSPEND_SETTLE,
                       RST_RUN_SETTLE};
      seq_levels = '0;
      enter_state(ST_G3);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The registers must come out of reset at their defaults.
      csr_access(REG_STOP_IN_S5, 1'b0, '0);
      csr_access(REG_RAIL_WAIT_LIMIT, 1'b0, '0);
      csr_access(REG_SUSPEND_SETTLE, 1'b0, '0);
      csr_access(REG_RUN_SETTLE, 1'b0, '0);

      for (p = 0; p < NUM_PHASES; p++) begin
         tx_idle = 1'b1;
         rx_idle = 1'b1;
         case (p)
            0: begin
               // Directed walk with zero settle times.
               plan = {1'b1, 16'd2, 10'd0, 10'd0};
               n_ticks = $size(walk_rows);
            end
            1: begin
               plan = {1'b0, 16'd3, 10'd1, 10'd2};
               n_ticks = 200;
            end
            2: begin
               // A wait limit of zero gives up after a single bad tick.
               plan = {1'b1, 16'd0, 10'd0, 10'd0};
               n_ticks = 150;
               tx_idle = 1'b0;
            end
            3: begin
               // Largest values: the block mostly sits in its settle counts.
               plan = {1'b1, 16'hFFFF, 10'h3FF, 10'h3FF};
               n_ticks = 60;
               rx_idle = 1'b0;
            end
            4: begin
               // Back-to-back on both sides, no idling at all.
               plan = {1'b0, 16'd1, 10'd2, 10'd3};
               n_ticks = 200;
               tx_idle = 1'b0;
               rx_idle = 1'b0;
            end
            5: begin
               // Sender streams while the receiver holds off for a long stretch.
               plan = {1'($urandom_range(0, 1)), 16'($urandom_range(1, 8)),
                       10'($urandom_range(0, 4)), 10'($urandom_range(0, 6))};
               n_ticks = 100;
               tx_idle = 1'b0;
            end
            default: begin
               plan = {1'($urandom_range(0, 1)), 16'($urandom_range(1, 8)),
                       10'($urandom_range(0, 4)), 10'($urandom_range(0, 6))};
               n_ticks = 215;
            end
         endcase

         // The block is idle here: every owed result has arrived and settled.
         junk = $urandom();
         csr_access(REG_STOP_IN_S5, 1'b1, {junk[31:1], plan.stop_in_s5});
         csr_access(REG_RAIL_WAIT_LIMIT, 1'b1, {junk[31:16], plan.rail_wait_limit});
         csr_access(REG_SUSPEND_SETTLE, 1'b1, {junk[31:10], plan.suspend_settle_ticks});
         csr_access(REG_RUN_SETTLE, 1'b1, {junk[31:10], plan.run_settle_ticks});

         if (p == 5) hold_long = 1'b1;
         drive_ticks(n_ticks, p == 0);

         while (due_outputs.size() != 0) @(posedge clock);
         repeat (SETTLE_DELAY) @(posedge clock);
      end

      $display("Checked %0d results from %0d ticks over %0d register settings.",
               results_checked, ticks_sent, NUM_PHASES);
      $display("Power states seen (bit per code): %b; ticks refused for %0d cycles.",
               states_seen[9:0], input_stalls);
      if (mismatches == 0) begin
         $display("acpi_power_state_sequencer test passed");
      end else begin
         $display("acpi_power_state_sequencer test failed");
      end
      $finish;
   end

endmodule
